/* rtl/dwf_pkg.sv */
// Shared types and constants of the chunked display write framer.
// No dependencies; the front end, queue, back end and top level refer to this package.
package dwf_pkg;

  localparam logic [7:0]  FRAME_SYNC0 = 8'h5A;
  localparam logic [7:0]  FRAME_SYNC1 = 8'hA5;
  localparam logic [7:0]  WRITE_CMD   = 8'h82;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  CHUNK_CAP   = 8'd250;
  localparam logic [7:0]  HDR_LEN_ADD = 8'd3;   // command + two address bytes
  localparam logic [7:0]  CRC_LEN_ADD = 8'd2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK  = 1'd1;
  localparam logic       CRC_ENABLE_RST = 1'b1;
  localparam logic [7:0] MAX_CHUNK_RST  = 8'd200;

  // one classified data beat, front to back
  typedef struct packed {
    logic        hdr;         // open a frame before this byte
    logic [7:0]  len_byte;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        crc_on;      // append CRC after this byte
    logic        last_frame;
    logic        last_msg;
  } dwf_cmd_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       message_end;
    logic       run_last;
  } dwf_res_t;

endpackage

/* rtl/dwf_in_if.sv */
// Input channel of the framer: one message data byte per beat.
// Depends on nothing.
interface dwf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] start_address;
  logic [15:0] message_length;

  modport source (output valid, output data_byte, output start_address,
                  output message_length, input ready);
  modport sink   (input valid, input data_byte, input start_address,
                  input message_length, output ready);
endinterface

/* rtl/dwf_out_if.sv */
// Result channel of the framer: one frame stream byte per beat.
// Depends on nothing.
interface dwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       message_end;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_end,
                  output message_end, output run_last, input ready);
  modport sink   (input valid, input out_byte, input frame_end,
                  input message_end, input run_last, output ready);
endinterface

/* rtl/dwf_front.sv */
// Front end: tracks message and chunk position, classifies each data beat.
// Depends on dwf_pkg.
module dwf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         start_address,
  input  logic [15:0]         message_length,
  input  logic                crc_enable,
  input  logic [7:0]          max_chunk,
  output dwf_pkg::dwf_cmd_t   cmd
);

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [15:0] base_address_r;
  logic [15:0] total_length_r;
  logic [7:0]  chunk_left_r, chunk_left_nxt;
  logic        crc_latched_r;

  logic        new_msg, hdr, lat, rest_short;
  logic [15:0] base, total, rest, off_after;
  logic [7:0]  cl, cap, clen, cl_after;

  always_comb begin
    new_msg = (byte_offset_r == 16'd0);
    base    = new_msg ? start_address : base_address_r;
    if (new_msg) begin
      total = (message_length == 16'd0) ? 16'd1 : message_length;
    end else begin
      total = total_length_r;
    end
    cl  = new_msg ? 8'd0 : chunk_left_r;
    hdr = (cl == 8'd0);

    priority if (max_chunk == 8'd0) begin
      cap = 8'd1;
    end else if (max_chunk > dwf_pkg::CHUNK_CAP) begin
      cap = dwf_pkg::CHUNK_CAP;
    end else begin
      cap = max_chunk;
    end

    rest       = total - byte_offset_r;
    rest_short = (rest < {8'd0, cap});
    clen       = rest_short ? rest[7:0] : cap;
    lat        = hdr ? crc_enable : crc_latched_r;

    cl_after  = (hdr ? clen : cl) - 8'd1;
    off_after = byte_offset_r + 16'd1;

    cmd.hdr        = hdr;
    cmd.len_byte   = clen + dwf_pkg::HDR_LEN_ADD + (lat ? dwf_pkg::CRC_LEN_ADD : 8'd0);
    cmd.addr       = base + {1'b0, byte_offset_r[15:1]};
    cmd.data       = data_byte;
    cmd.last_frame = (cl_after == 8'd0);
    cmd.last_msg   = cmd.last_frame && (off_after >= total);
    cmd.crc_on     = cmd.last_frame && lat;

    if (cmd.last_msg) begin
      byte_offset_nxt = 16'd0;
      chunk_left_nxt  = 8'd0;
    end else begin
      byte_offset_nxt = off_after;
      chunk_left_nxt  = cl_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= 16'd0;
      base_address_r <= 16'd0;
      total_length_r <= 16'd0;
      chunk_left_r   <= 8'd0;
      crc_latched_r  <= 1'b1;
    end else if (accept) begin
      byte_offset_r  <= byte_offset_nxt;
      base_address_r <= base;
      total_length_r <= total;
      chunk_left_r   <= chunk_left_nxt;
      crc_latched_r  <= lat;
    end
  end

endmodule

/* rtl/dwf_queue.sv */
// Short command queue between front and back ends.
// Depends on dwf_pkg for the command type.
module dwf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dwf_pkg::dwf_cmd_t push_cmd,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output dwf_pkg::dwf_cmd_t head_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dwf_pkg::dwf_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign not_full   = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full) else $error("push into full queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");

endmodule

/* rtl/dwf_back.sv */
// Back end: expands each queued command into frame bytes, keeps the CRC.
// Depends on dwf_pkg.
module dwf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  dwf_pkg::dwf_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output dwf_pkg::dwf_res_t out_res
);

  typedef enum logic [3:0] {
    S_SYNC0, S_SYNC1, S_LEN, S_CMD, S_ADDR_H, S_ADDR_L, S_DATA, S_CRC_L, S_CRC_H
  } step_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ dwf_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  step_t       step_r, cur, step_nxt;
  logic        mid_r;
  logic        out_valid_r;
  logic [15:0] crc_r, crc_nxt;
  dwf_pkg::dwf_res_t res_r;
  logic [7:0]  byte_sel;
  logic        final_byte, advance;

  always_comb begin
    if (mid_r) begin
      cur = step_r;
    end else begin
      cur = head_cmd.hdr ? S_SYNC0 : S_DATA;
    end
    crc_nxt  = crc_r;
    step_nxt = cur;
    unique case (cur)
      S_SYNC0:  begin byte_sel = dwf_pkg::FRAME_SYNC0; step_nxt = S_SYNC1; end
      S_SYNC1:  begin byte_sel = dwf_pkg::FRAME_SYNC1; step_nxt = S_LEN; end
      S_LEN:    begin byte_sel = head_cmd.len_byte;    step_nxt = S_CMD; end
      S_CMD: begin
        byte_sel = dwf_pkg::WRITE_CMD;
        crc_nxt  = crc_feed(dwf_pkg::CRC_INIT, dwf_pkg::WRITE_CMD);
        step_nxt = S_ADDR_H;
      end
      S_ADDR_H: begin
        byte_sel = head_cmd.addr[15:8];
        crc_nxt  = crc_feed(crc_r, head_cmd.addr[15:8]);
        step_nxt = S_ADDR_L;
      end
      S_ADDR_L: begin
        byte_sel = head_cmd.addr[7:0];
        crc_nxt  = crc_feed(crc_r, head_cmd.addr[7:0]);
        step_nxt = S_DATA;
      end
      S_DATA: begin
        byte_sel = head_cmd.data;
        crc_nxt  = crc_feed(crc_r, head_cmd.data);
        step_nxt = S_CRC_L;
      end
      S_CRC_L:  begin byte_sel = crc_r[7:0];  step_nxt = S_CRC_H; end
      S_CRC_H:  begin byte_sel = crc_r[15:8]; step_nxt = S_SYNC0; end
      default:  begin byte_sel = 8'd0;        step_nxt = S_SYNC0; end
    endcase
    final_byte = ((cur == S_DATA) && !head_cmd.crc_on) || (cur == S_CRC_H);
    advance    = head_valid && (!out_valid_r || out_ready);
  end

  assign pop       = advance && final_byte;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_SYNC0;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= dwf_pkg::CRC_INIT;
    end else begin
      if (advance) begin
        step_r            <= step_nxt;
        mid_r             <= !final_byte;
        crc_r             <= crc_nxt;
        out_valid_r       <= 1'b1;
        res_r.out_byte    <= byte_sel;
        res_r.frame_end   <= final_byte && head_cmd.last_frame;
        res_r.message_end <= final_byte && head_cmd.last_msg;
        res_r.run_last    <= final_byte;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* rtl/display_write_framer_crc16.sv */
// Top level of the chunked display write framer with CRC-16/MODBUS.
// Depends on dwf_pkg, dwf_in_if, dwf_out_if, dwf_front, dwf_queue, dwf_back.
//
//  channel  | dir | beat carries                                   | accepted when
//  ---------+-----+------------------------------------------------+---------------------
//  in_ch    | in  | data_byte, start_address, message_length       | valid && ready
//  out_ch   | out | out_byte, frame_end, message_end, run_last     | valid && ready
//  cfg_*    | in  | cfg_index, cfg_wdata (crc_enable, max_chunk)   | cfg_we
//
// Bytes: a data byte inside a frame emits one byte; a byte that opens a frame emits
// seven (six header bytes plus the data), and one that closes a frame with CRC on
// two more. The emitter sends a byte per cycle unless out_ch or an empty queue holds it.
// Reset: one cycle of rst_n low; no clearing sweep.
// Stalls: the queue lets the front keep taking beats while the emitter works
// or the output waits; in_ch.ready drops only when the queue is full.
module display_write_framer_crc16 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dwf_in_if.sink                              in_ch,
  dwf_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [dwf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration registers; sampled by the front end at each frame header
  logic       crc_enable_r;
  logic [7:0] max_chunk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_enable_r <= dwf_pkg::CRC_ENABLE_RST;
      max_chunk_r  <= dwf_pkg::MAX_CHUNK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dwf_pkg::REG_CRC_ENABLE: crc_enable_r <= cfg_wdata[0];
        dwf_pkg::REG_MAX_CHUNK:  max_chunk_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic              in_accept;
  logic              q_not_full, q_valid, q_pop;
  dwf_pkg::dwf_cmd_t front_cmd, head_cmd;
  dwf_pkg::dwf_res_t res;

  assign in_ch.ready = q_not_full;
  assign in_accept   = in_ch.valid && q_not_full;

  // front: message / chunk bookkeeping, one beat per cycle while the queue has room
  dwf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .data_byte      (in_ch.data_byte),
    .start_address  (in_ch.start_address),
    .message_length (in_ch.message_length),
    .crc_enable     (crc_enable_r),
    .max_chunk      (max_chunk_r),
    .cmd            (front_cmd)
  );

  // decoupling queue
  dwf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_cmd   (front_cmd),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // back: byte emitter with running CRC and registered output
  dwf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (res)
  );

  assign out_ch.out_byte    = res.out_byte;
  assign out_ch.frame_end   = res.frame_end;
  assign out_ch.message_end = res.message_end;
  assign out_ch.run_last    = res.run_last;

endmodule
